// ===== hdl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the matrix-vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned ValueW         = 16;
  localparam int unsigned ProdW          = 32;
  localparam int unsigned SumW           = 48;
  localparam int unsigned RowW           = 12;
  localparam int unsigned NumColsW       = 11;
  localparam int unsigned NumRowsW       = 13;
  localparam int unsigned PaddrW         = 3;
  localparam int unsigned PdataW         = 32;
  localparam int unsigned MaxColsDefault = 1024;
  localparam int unsigned QueueDepth     = 4;

  localparam logic [NumRowsW-1:0] RowLimit     = 13'd4096;
  localparam logic [NumColsW-1:0] NumColsReset = 11'd64;
  localparam logic [NumRowsW-1:0] NumRowsReset = 13'd64;

  // opcodes
  localparam logic OpVecLoad = 1'b0;
  localparam logic OpMatElem = 1'b1;

  // register index, taken from paddr[2]
  localparam logic RegNumCols = 1'b0;
  localparam logic RegNumRows = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [ValueW-1:0] value;
  } mvm_in_t;

  typedef struct packed {
    logic signed [SumW-1:0] row_sum;
    logic [RowW-1:0]        row_index;
    logic                   last_row;
  } mvm_out_t;

  // one command from the front end to the datapath
  typedef struct packed {
    logic                     is_mac;
    logic signed [ValueW-1:0] value;
    logic signed [ValueW-1:0] vec_elem;
    logic                     last_col;
    logic [RowW-1:0]          row_index;
    logic                     last_row;
  } mvm_cmd_t;

endpackage

// ===== hdl/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// mvm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mvm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mvm_front.sv =====
// ----------------------------------------------------------------------------
// mvm_front
// Accepts requests, keeps the load/column/row counters, owns the vector
// store and issues one command per request towards the datapath.
// ----------------------------------------------------------------------------
module mvm_front
  import mvm_pkg::*;
#(
  parameter int unsigned MaxCols = MaxColsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mvm_in_t             in_data_i,
  input  logic [NumColsW-1:0] num_cols_i,
  input  logic [NumRowsW-1:0] num_rows_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output mvm_cmd_t            cmd_o
);

  localparam int unsigned ColW = $clog2(MaxCols);
  localparam int unsigned EffW = $clog2(MaxCols + 1);
  localparam int unsigned CmpW = (EffW > NumColsW) ? EffW : NumColsW;
  localparam logic [CmpW-1:0] MaxColsC = CmpW'(MaxCols);
  localparam logic [ColW-1:0] LastIdx  = ColW'(MaxCols - 1);

  logic [ColW-1:0] load_idx_q, load_idx_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            f_valid_q, f_valid_d;
  mvm_cmd_t        f_cmd_q, f_cmd_d;

  logic [CmpW-1:0]     ncols_ext, eff_cols, col_next;
  logic [NumRowsW-1:0] eff_rows, row_next;
  logic                last_col, last_row, accept, push, is_load;
  logic [ValueW-1:0]   ram_rdata;

  assign push       = f_valid_q && cmd_ready_i;
  assign in_ready_o = !f_valid_q || push;
  assign accept     = in_valid_i && in_ready_o;
  assign is_load    = (in_data_i.opcode == OpVecLoad);

  always_comb begin
    ncols_ext = CmpW'(num_cols_i);
    if (ncols_ext == '0) begin
      eff_cols = CmpW'(1);
    end else if (ncols_ext > MaxColsC) begin
      eff_cols = MaxColsC;
    end else begin
      eff_cols = ncols_ext;
    end
    if (num_rows_i == '0) begin
      eff_rows = NumRowsW'(1);
    end else if (num_rows_i > RowLimit) begin
      eff_rows = RowLimit;
    end else begin
      eff_rows = num_rows_i;
    end
    col_next = CmpW'(col_q) + CmpW'(1);
    row_next = {1'b0, row_q} + NumRowsW'(1);
    // a shrunken num_cols also closes the row at once
    last_col = !(col_next < eff_cols);
    last_row = (row_next >= eff_rows);
  end

  always_comb begin
    load_idx_d = load_idx_q;
    col_d      = col_q;
    row_d      = row_q;
    f_valid_d  = f_valid_q;
    f_cmd_d    = f_cmd_q;
    if (push) begin
      f_valid_d = 1'b0;
    end
    if (accept) begin
      f_valid_d         = 1'b1;
      f_cmd_d.value     = in_data_i.value;
      f_cmd_d.vec_elem  = '0;
      f_cmd_d.row_index = row_q;
      if (is_load) begin
        load_idx_d       = (load_idx_q == LastIdx) ? '0 : load_idx_q + ColW'(1);
        col_d            = '0;
        row_d            = '0;
        f_cmd_d.is_mac   = 1'b0;
        f_cmd_d.last_col = 1'b0;
        f_cmd_d.last_row = 1'b0;
      end else begin
        load_idx_d       = '0;
        f_cmd_d.is_mac   = 1'b1;
        f_cmd_d.last_col = last_col;
        f_cmd_d.last_row = last_row;
        if (last_col) begin
          col_d = '0;
          row_d = last_row ? '0 : row_q + RowW'(1);
        end else begin
          col_d = col_q + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      f_valid_q  <= 1'b0;
    end else begin
      load_idx_q <= load_idx_d;
      col_q      <= col_d;
      row_q      <= row_d;
      f_valid_q  <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_cmd_q <= f_cmd_d;
  end

  // read data lands together with the staged request
  mvm_ram #(
    .Width (ValueW),
    .Depth (MaxCols)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (load_idx_q),
    .wdata_i (in_data_i.value),
    .re_i    (accept && !is_load),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cmd_o          = f_cmd_q;
    cmd_o.vec_elem = ram_rdata;
  end

  assign cmd_valid_o = f_valid_q;

endmodule

// ===== hdl/mvm_queue.sv =====
// ----------------------------------------------------------------------------
// mvm_queue
// Small register FIFO between the front end and the datapath.
// ----------------------------------------------------------------------------
module mvm_queue
  import mvm_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  mvm_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output mvm_cmd_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  mvm_cmd_t        slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/mvm_back.sv =====
// ----------------------------------------------------------------------------
// mvm_back
// Multiply-accumulate datapath: product stage, then accumulator and
// result register.
// ----------------------------------------------------------------------------
module mvm_back
  import mvm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  mvm_cmd_t cmd_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mvm_out_t out_data_o
);

  logic                   adv;
  logic                   p_valid_q, p_mac_q, p_last_col_q, p_last_row_q;
  logic signed [ProdW-1:0] p_prod_q;
  logic [RowW-1:0]        p_row_q;
  logic signed [SumW-1:0] acc_q, acc_d, sum;
  logic                   out_valid_q, out_valid_d;
  mvm_out_t               out_q, out_d;

  // whole pipe holds while a finished sum waits
  assign adv         = !out_valid_q || out_ready_i;
  assign cmd_ready_o = adv;

  always_ff @(posedge clk_i) begin
    if (adv && cmd_valid_i) begin
      p_mac_q      <= cmd_i.is_mac;
      p_prod_q     <= cmd_i.value * cmd_i.vec_elem;
      p_last_col_q <= cmd_i.last_col;
      p_row_q      <= cmd_i.row_index;
      p_last_row_q <= cmd_i.last_row;
    end
  end

  always_comb begin
    sum         = acc_q + SumW'(p_prod_q);
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = 1'b0;
      if (p_valid_q) begin
        if (!p_mac_q) begin
          acc_d = '0;
        end else if (p_last_col_q) begin
          acc_d           = '0;
          out_valid_d     = 1'b1;
          out_d.row_sum   = sum;
          out_d.row_index = p_row_q;
          out_d.last_row  = p_last_row_q;
        end else begin
          acc_d = sum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        p_valid_q <= cmd_valid_i;
      end
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/matrix_vector_multiply_core.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Streaming matrix-vector product, Q4.12 inputs, Q24.24 row sums.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_valid/in_ready  | opcode, value
//  out     | out | out_valid/out_ready| row_sum, row_index, last_row
//  apb     | in  | psel/penable/pready| num_cols @0x0, num_rows @0x4
//
//  One request per cycle, vector loads and matrix elements alike, unless a full queue holds the front.
//  After its last element is taken, a row sum passes through the front
//  register, queue, product register and accumulator/result register.
//  Vector store is uninitialised after reset; no clearing pass.
//  A held result stalls the datapath; the queue lets the front keep going until it is full.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core
  import mvm_pkg::*;
#(
  parameter int unsigned MaxCols = MaxColsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mvm_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mvm_out_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [NumColsW-1:0] num_cols_q;
  logic [NumRowsW-1:0] num_rows_q;
  logic                wr_en;
  logic                f_valid, f_ready, b_valid, b_ready;
  mvm_cmd_t            f_cmd, b_cmd;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NumColsReset;
      num_rows_q <= NumRowsReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegNumCols: num_cols_q <= pwdata[NumColsW-1:0];
        RegNumRows: num_rows_q <= pwdata[NumRowsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegNumCols: prdata = PdataW'(num_cols_q);
      RegNumRows: prdata = PdataW'(num_rows_q);
      default:    prdata = '0;
    endcase
  end

  mvm_front #(
    .MaxCols (MaxCols)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .num_cols_i  (num_cols_q),
    .num_rows_i  (num_rows_q),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  mvm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  mvm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/mvm_checker.sv =====
// ----------------------------------------------------------------------------
// mvm_checker
// Port-level checks on the matrix-vector multiply core, bound to the top.
// ----------------------------------------------------------------------------
module mvm_checker
  import mvm_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input mvm_in_t           in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mvm_out_t          out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [PaddrW-1:0] paddr,
  input logic [PdataW-1:0] pwdata,
  input logic [PdataW-1:0] prdata,
  input logic              pready
);

  logic mat_seen_q;

  // set once any matrix element has been taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_seen_q <= 1'b0;
    end else if (in_valid_i && in_ready_o && (in_data_i.opcode == OpMatElem)) begin
      mat_seen_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mat_seen_q)
    else $error("row sum without any matrix element");

  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(psel && penable && pwrite && pready) && psel && !pwrite
      && (paddr[2] == $past(paddr[2]))
    |-> prdata == ((paddr[2] == RegNumRows) ? PdataW'($past(pwdata[NumRowsW-1:0]))
                                            : PdataW'($past(pwdata[NumColsW-1:0]))))
    else $error("register readback mismatch");

endmodule

bind matrix_vector_multiply_core mvm_checker u_mvm_checker (.*);
